>>> rtl/lmwc_pkg.sv
// Shared constants and helpers for the lag multiply-with-carry generator.
package lmwc_pkg;

  localparam logic [1:0] ACT_SEED = 2'd0;
  localparam logic [1:0] ACT_WORD = 2'd1;
  localparam logic [1:0] ACT_BYTE = 2'd2;

  localparam logic [2:0] BYTES_WORD = 3'd4;
  localparam logic [2:0] BYTES_ONE  = 3'd1;

  localparam logic [29:0] MWC_MULT    = 30'd611376378;
  localparam logic [31:0] CARRY_RESET = 32'd123;

  // Even readings are byte-reversed; only the low word of the result is kept.
  function automatic logic [31:0] seed_word(input logic [63:0] cv);
    logic [31:0] w;
    if (cv[0]) begin
      w = cv[31:0];
    end else begin
      w = {cv[39:32], cv[47:40], cv[55:48], cv[63:56]};
    end
    return w;
  endfunction

endpackage

>>> rtl/lag_1038_multiply_with_carry_rng_top.sv
// Top level of the lag multiply-with-carry random generator.
//
// Lag multiply-with-carry generator. Seed items (action 0) with an index
// inside the table write one table word formed from a counter reading;
// draws (action 1 word, action 2 byte) return one result each. One item is
// taken per cycle while in_ready is high; it stays low while a draw in the
// execute stage waits for the output register to free up for its result.
// The carry loop (30x32 multiply-add into the carry register) closes through
// the carry register alone, and the table word a draw writes is forwarded to
// the next draw's read of the same entry. After reset the table is cleared
// to zero, one entry per cycle, and in_ready stays low until it is done.
module lag_1038_multiply_with_carry_rng_top #(
  parameter int TABLE_DEPTH = 1038
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [10:0] seed_index,
  input  logic [63:0] counter_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] random_value,
  output logic [2:0]  byte_count
);
  import lmwc_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_POS = AW'(TABLE_DEPTH - 1);

  // clearing pass
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // current lag position, advanced at draw transfer
  logic [AW-1:0] pos;
  logic [AW-1:0] pos_next;

  // execute stage: one item after its table read
  logic          b_valid;
  logic          b_draw;
  logic          b_byte;
  logic          b_seed_we;
  logic [AW-1:0] b_waddr;
  logic [31:0]   b_seed_data;
  logic          fwd;
  logic [31:0]   fwd_data;

  logic          accept;
  logic          is_draw;
  logic          out_free;
  logic          b_done;
  logic          b_write;
  logic [31:0]   b_wdata;
  logic [31:0]   mem_q;
  logic [31:0]   operand;
  logic [31:0]   low;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;

  assign is_draw  = (action == ACT_WORD) || (action == ACT_BYTE);
  assign out_free = !out_valid || out_ready;
  assign b_done   = b_valid && (!b_draw || out_free);
  assign in_ready = !clearing && (!b_valid || b_done);
  assign accept   = in_valid && in_ready;

  // wrap from entry 1 back to the top of the table
  assign pos_next = (pos == AW'(1)) ? LAST_POS : pos - AW'(1);

  assign operand = fwd ? fwd_data : mem_q;
  assign b_write = b_done && (b_draw || b_seed_we);
  assign b_wdata = b_draw ? low : b_seed_data;

  assign ram_we    = clearing || b_write;
  assign ram_waddr = clearing ? clr_addr : b_waddr;
  assign ram_wdata = clearing ? 32'd0 : b_wdata;

  lmwc_table_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (pos),
    .rdata (mem_q)
  );

  lmwc_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .operand (operand),
    .update  (b_done && b_draw),
    .low     (low)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == LAST_POS) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= LAST_POS;
    end else if (accept && is_draw) begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (accept) begin
      b_valid <= 1'b1;
    end else if (b_done) begin
      b_valid <= 1'b0;
    end
  end

  // payload of the execute stage; forward a write landing on the entry read now
  always_ff @(posedge clk) begin
    if (accept) begin
      b_draw      <= is_draw;
      b_byte      <= (action == ACT_BYTE);
      b_seed_we   <= (action == ACT_SEED) && (seed_index < 11'(TABLE_DEPTH));
      b_waddr     <= is_draw ? pos - AW'(1) : seed_index[AW-1:0];
      b_seed_data <= seed_word(counter_value);
      fwd         <= b_write && (b_waddr == pos);
      fwd_data    <= b_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_done && b_draw) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_done && b_draw) begin
      random_value <= b_byte ? {24'd0, low[7:0]} : low;
      byte_count   <= b_byte ? BYTES_ONE : BYTES_WORD;
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (pos != '0) && (pos <= LAST_POS))
    else $error("lag position out of range");

  a_draw_enters: assert property (@(posedge clk) disable iff (rst)
    (accept && is_draw) |=> (b_valid && b_draw))
    else $error("draw transfer did not reach execute stage");

  a_draw_result: assert property (@(posedge clk) disable iff (rst)
    (b_done && b_draw) |=> out_valid)
    else $error("finished draw left no result");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!in_ready && !b_valid))
    else $error("activity during clearing pass");
`endif

endmodule

>>> rtl/lmwc_table_ram.sv
// Lag table storage: one write port, one registered read port.
module lmwc_table_ram #(
  parameter int DEPTH = 1038,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  // read returns the old word on a same-address write; the caller forwards
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/lmwc_mac.sv
// Multiply-add unit with the carry register.
module lmwc_mac (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] operand,
  input  logic        update,
  output logic [31:0] low
);
  import lmwc_pkg::*;

  logic [31:0] carry;
  logic [63:0] t;

  assign t   = 64'(MWC_MULT) * 64'(operand) + 64'(carry);
  assign low = t[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      carry <= CARRY_RESET;
    end else if (update) begin
      carry <= t[63:32];
    end
  end

endmodule

>>> sim/tb_lag_1038_multiply_with_carry_rng_top.sv
// Testbench for the lag-1038 multiply-with-carry generator: random and directed items, checked.
`timescale 1ns / 1ps

module tb_lag_1038_multiply_with_carry_rng_top;
  import lmwc_pkg::*;

  localparam int DEPTH = 1038;
  localparam int ITEM_GOAL = 1750;
  // last stretch of the run goes without any idling on either side
  localparam int QUIET_TAIL = 250;
  // covers the table clearing pass after reset plus the long output hold-offs
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 150;
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam logic [63:0] MWC_FACTOR = 64'd611376378;

  typedef struct packed {
    logic [1:0]  act;
    logic [10:0] idx;
    logic [63:0] cv;
    logic        barrier;  // sender waits here until all draws are back
    logic        quiet;    // part of the no-idle tail
  } feed_item_t;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  nbytes;
  } draw_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = ACT_SEED;
  logic [10:0] seed_index = '0;
  logic [63:0] counter_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] random_value;
  logic [2:0]  byte_count;

  // items waiting to be offered, and draws accepted but not yet returned
  feed_item_t feed_q[$];
  draw_t      draws_due[$];

  // generator mirror: table, carry and read position
  logic [31:0] mwc_table [DEPTH];
  logic [31:0] mwc_carry;
  logic [10:0] mwc_pos;

  // read position as seen while building the stimulus (used to aim seeds)
  logic [10:0] plan_pos;
  int          planned;

  feed_item_t  cur_item;
  draw_t       due_draw;
  logic [31:0] draw_word;
  logic        calm = 1'b0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  int          holds_done = 0;
  int          results_seen = 0;
  int          quiet_cycles = 0;
  int          failures = 0;
  int          n_seeds = 0;
  int          n_ignored = 0;
  int          n_words = 0;
  int          n_bytes = 0;
  int          n_wraps = 0;

  lag_1038_multiply_with_carry_rng_top #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .seed_index   (seed_index),
    .counter_value(counter_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .random_value (random_value),
    .byte_count   (byte_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Seed word: an even reading gets its eight bytes reversed, then the low
  // 32 bits are kept.
  function automatic logic [31:0] seed_value(input logic [63:0] cv);
    logic [63:0] r;
    if (cv[0]) begin
      return cv[31:0];
    end
    for (int k = 0; k < 8; k++) begin
      r[8*k +: 8] = cv[56-8*k +: 8];
    end
    return r[31:0];
  endfunction

  // One multiply-with-carry step: read at the current position, carry takes
  // the high half, the low half lands one entry lower. Reaching entry 0 wraps
  // the position back to the top of the table.
  function automatic logic [31:0] mwc_advance();
    logic [63:0] t;
    logic [10:0] p;
    p = mwc_pos;
    t = MWC_FACTOR * {32'd0, mwc_table[p]} + {32'd0, mwc_carry};
    mwc_carry = t[63:32];
    p = p - 11'd1;
    mwc_table[p] = t[31:0];
    if (p == 11'd0) begin
      mwc_pos = 11'(DEPTH - 1);
      n_wraps++;
    end else begin
      mwc_pos = p;
    end
    return t[31:0];
  endfunction

  // Queue one item; ignored items (unused action, seed past the table) do
  // not count toward the goal.
  task automatic add_item(input logic [1:0] act, input logic [10:0] idx,
                          input logic [63:0] cv);
    feed_item_t it;
    it.act = act;
    it.idx = idx;
    it.cv = cv;
    it.barrier = 1'b0;
    it.quiet = (planned >= ITEM_GOAL - QUIET_TAIL);
    feed_q.push_back(it);
    if (act == ACT_WORD || act == ACT_BYTE) begin
      plan_pos = (plan_pos == 11'd1) ? 11'(DEPTH - 1) : plan_pos - 11'd1;
    end
    if (act != ACT_NONE && !(act == ACT_SEED && idx >= DEPTH)) begin
      planned++;
    end
  endtask

  task automatic add_barrier();
    feed_item_t it;
    it = '0;
    it.barrier = 1'b1;
    feed_q.push_back(it);
  endtask

  function automatic logic [63:0] rand_reading();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Sender: offers the head of feed_q, holds the payload until the transfer,
  // and inserts short idle bursts after some transfers. The model is updated
  // at each accepted transfer, in acceptance order.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        case (action)
          ACT_SEED: begin
            if (seed_index < DEPTH) begin
              mwc_table[seed_index] = seed_value(counter_value);
              n_seeds++;
            end else begin
              n_ignored++;
            end
          end
          ACT_WORD: begin
            draw_word = mwc_advance();
            draws_due.push_back('{draw_word, BYTES_WORD});
            n_words++;
          end
          ACT_BYTE: begin
            draw_word = mwc_advance();
            draws_due.push_back('{{24'd0, draw_word[7:0]}, BYTES_ONE});
            n_bytes++;
          end
          default: n_ignored++;
        endcase
      end
      if (!in_valid || in_ready) begin
        if (in_valid && in_ready && !calm && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 3);
          in_valid <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (feed_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (feed_q[0].barrier) begin
          // pause the sender until every draw in flight has come back
          if (draws_due.size() == 0) begin
            void'(feed_q.pop_front());
          end
          in_valid <= 1'b0;
        end else begin
          cur_item = feed_q.pop_front();
          action <= cur_item.act;
          seed_index <= cur_item.idx;
          counter_value <= cur_item.cv;
          in_valid <= 1'b1;
          if (cur_item.quiet) begin
            calm <= 1'b1;
          end
        end
      end
    end
  end

  // Receiver: checks each transfer against the oldest pending draw and
  // drives out_ready with short random stalls plus two long hold-offs that
  // back the block up into its input.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (draws_due.size() == 0) begin
          $error("unexpected result: random_value %h byte_count %0d",
                 random_value, byte_count);
          failures++;
        end else begin
          due_draw = draws_due.pop_front();
          if (random_value !== due_draw.value) begin
            $error("random_value: expected %h, got %h", due_draw.value, random_value);
            failures++;
          end
          if (byte_count !== due_draw.nbytes) begin
            $error("byte_count: expected %0d, got %0d", due_draw.nbytes, byte_count);
            failures++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if ((holds_done == 0 && results_seen >= 100) ||
                   (holds_done == 1 && results_seen >= 700)) begin
        holds_done++;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: any stretch without a transfer on either side that runs this
  // long means the block has hung.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int r;
    int pauses;
    pauses = 0;
    for (int i = 0; i < DEPTH; i++) begin
      mwc_table[i] = 32'd0;
    end
    mwc_carry = CARRY_RESET;
    mwc_pos = 11'(DEPTH - 1);
    plan_pos = 11'(DEPTH - 1);
    planned = 0;

    // Directed: draws from the cleared table, seeds at both ends with odd and
    // even readings, a seed aimed at the entry about to be read, ignored
    // items (seed past the table, unused action), both draw kinds.
    add_item(ACT_WORD, 11'd0, 64'd0);
    add_item(ACT_BYTE, 11'd0, 64'd0);
    add_item(ACT_SEED, 11'(DEPTH - 1), 64'd0);
    add_item(ACT_SEED, 11'(DEPTH - 1), '1);
    add_item(ACT_SEED, 11'd0, 64'h0123_4567_89AB_CDEE);
    add_item(ACT_SEED, 11'd1, 64'h8000_0000_0000_0001);
    add_item(ACT_SEED, plan_pos, 64'hFEDC_BA98_7654_3210);
    add_item(ACT_WORD, 11'd0, '1);
    add_item(ACT_SEED, 11'(DEPTH), '1);
    add_item(ACT_SEED, 11'h7FF, 64'h5555_5555_5555_5554);
    add_item(ACT_NONE, 11'h7FF, '1);
    add_item(ACT_BYTE, 11'h7FF, 64'hAAAA_AAAA_AAAA_AAAB);
    add_item(ACT_SEED, plan_pos, 64'hFFFF_FFFF_0000_0002);
    add_item(ACT_BYTE, 11'd0, 64'd0);
    add_item(ACT_SEED, plan_pos - 11'd1, 64'h0000_0000_FFFF_FFFF);
    add_item(ACT_WORD, 11'd0, 64'd0);
    add_item(ACT_WORD, 11'd0, 64'd0);
    add_item(ACT_NONE, 11'd0, 64'd0);
    add_item(ACT_WORD, 11'd0, 64'd0);

    // Random: mostly draws so the read position runs through the whole table
    // and wraps; seeds often aim at the entry read next, the one written
    // next, or the top entry read right after a wrap.
    while (planned < ITEM_GOAL) begin
      if ((pauses == 0 && planned >= 600) || (pauses == 1 && planned >= 1200)) begin
        add_barrier();
        pauses++;
      end
      r = $urandom_range(0, 99);
      if (r < 38) begin
        add_item(ACT_WORD, 11'($urandom), rand_reading());
      end else if (r < 72) begin
        add_item(ACT_BYTE, 11'($urandom), rand_reading());
      end else if (r < 84) begin
        add_item(ACT_SEED, 11'($urandom_range(0, DEPTH - 1)), rand_reading());
      end else if (r < 95) begin
        case ($urandom_range(0, 2))
          0: add_item(ACT_SEED, plan_pos, rand_reading());
          1: add_item(ACT_SEED, plan_pos - 11'd1, rand_reading());
          default: add_item(ACT_SEED, 11'(DEPTH - 1), rand_reading());
        endcase
      end else if (r < 98) begin
        add_item(ACT_SEED, 11'($urandom_range(DEPTH, 2047)), rand_reading());
      end else begin
        add_item(ACT_NONE, 11'($urandom), rand_reading());
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (feed_q.size() != 0 || in_valid || draws_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (16) @(posedge clk);
    if (draws_due.size() != 0) begin
      $error("%0d draws never returned", draws_due.size());
      failures++;
    end

    $display("tb: %0d seeds, %0d word draws, %0d byte draws, %0d ignored items",
             n_seeds, n_words, n_bytes, n_ignored);
    $display("tb: %0d results checked, %0d table wraps, %0d mismatches",
             results_seen, n_wraps, failures);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
